// ===== hdl/ready_queue_scheduler_macros.svh =====
// Assertion helpers for the ready queue scheduler.
`ifndef READY_QUEUE_SCHEDULER_MACROS_SVH
`define READY_QUEUE_SCHEDULER_MACROS_SVH

// Clocked check, off while reset is asserted.
`define RQS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked in the same cycle.
`define RQS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rqs_pkg.sv =====
`timescale 1ns / 1ps
package rqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int KEY_BITS    = 8;
  localparam int ID_W        = 8;
  localparam int LIM_W       = 6;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SJF   = 2'd1,
    POL_RR    = 2'd2,
    POL_AGING = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    KIND_ENQ    = 2'd0,
    KIND_DISP   = 2'd1,
    KIND_REPORT = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOPROC = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    INS_TAIL      = 2'd0,
    INS_HEAD      = 2'd1,
    INS_SORT_LEN  = 2'd2,
    INS_SORT_SC   = 2'd3
  } ins_mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_AGE,
    S_CHECK,
    S_CMP,
    S_WRITE,
    S_DONE
  } state_e;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic      latch_item;
    logic      pop;
    logic      age;
    logic      cmp;
    logic      insert;
    ins_mode_e ins_mode;
    logic      use_run;
    logic      clear_run;
    logic      load_result;
    logic      grant;
    status_e   res_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  full;
    logic  empty;
    logic  run_valid;
    logic  head_lt_run;
    kind_e kind;
    logic  fin;
  } sts_t;

endpackage

// ===== hdl/rqs_datapath.sv =====
`timescale 1ns / 1ps
module rqs_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rqs_pkg::cmd_t                 cmd_i,
  output rqs_pkg::sts_t                 sts_o,
  input  rqs_pkg::policy_e              policy_i,
  input  logic [rqs_pkg::LIM_W-1:0]     quantum_i,
  input  logic [1:0]                    kind_i,
  input  logic [rqs_pkg::ID_W-1:0]      proc_id_i,
  input  logic [rqs_pkg::KEY_BITS-1:0]  job_length_i,
  input  logic [rqs_pkg::KEY_BITS-1:0]  age_score_i,
  input  logic                          finished_i,
  output logic [rqs_pkg::ID_W-1:0]      granted_id_o,
  output logic [rqs_pkg::LIM_W-1:0]     run_limit_o,
  output logic [1:0]                    status_o,
  output logic [rqs_pkg::CNT_W-1:0]     occupancy_o
);

  localparam int D  = rqs_pkg::QUEUE_DEPTH;
  localparam int KB = rqs_pkg::KEY_BITS;
  localparam int CW = rqs_pkg::CNT_W;

  logic [rqs_pkg::ID_W-1:0] slot_id_q  [D];
  logic [KB-1:0]            slot_len_q [D];
  logic [KB-1:0]            slot_sc_q  [D];
  logic [CW-1:0]            count_q, count_d;

  logic [rqs_pkg::ID_W-1:0] run_id_q;
  logic [KB-1:0]            run_len_q, run_sc_q;
  logic                     run_valid_q;

  rqs_pkg::kind_e           item_kind_q;
  logic [rqs_pkg::ID_W-1:0] item_id_q;
  logic [KB-1:0]            item_len_q, item_sc_q;
  logic                     item_fin_q;

  logic [D-1:0]             gt_q, gt_d;
  logic                     head_lt_q, head_lt_d;

  logic [rqs_pkg::ID_W-1:0] src_id;
  logic [KB-1:0]            src_len, src_sc, key;
  logic [CW-1:0]            pos;
  logic [rqs_pkg::LIM_W-1:0] limit;

  always_comb begin
    src_id  = cmd_i.use_run ? run_id_q  : item_id_q;
    src_len = cmd_i.use_run ? run_len_q : item_len_q;
    src_sc  = cmd_i.use_run ? run_sc_q  : item_sc_q;
    key     = (cmd_i.ins_mode == rqs_pkg::INS_SORT_LEN) ? src_len : src_sc;
  end

  // per-slot compare, registered before the write
  always_comb begin
    logic [KB-1:0] sk;
    for (int i = 0; i < D; i++) begin
      sk = (cmd_i.ins_mode == rqs_pkg::INS_SORT_LEN) ? slot_len_q[i] : slot_sc_q[i];
      gt_d[i] = (i >= 1) && (CW'(i) < count_q) && (sk > key);
    end
    sk = (cmd_i.ins_mode == rqs_pkg::INS_SORT_LEN) ? slot_len_q[0] : slot_sc_q[0];
    head_lt_d = (count_q == '0) || (key < sk);
  end

  always_comb begin
    unique case (cmd_i.ins_mode)
      rqs_pkg::INS_TAIL: pos = count_q;
      rqs_pkg::INS_HEAD: pos = '0;
      default: begin
        pos = count_q;
        for (int i = D - 1; i >= 1; i--) begin
          if (gt_q[i]) pos = CW'(i);
        end
        if (head_lt_q) pos = '0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.pop) count_d = count_q - CW'(1);
    else if (cmd_i.insert) count_d = count_q + CW'(1);
  end

  always_comb begin
    unique case (policy_i)
      rqs_pkg::POL_RR:    limit = (quantum_i == '0) ? rqs_pkg::LIM_W'(1) : quantum_i;
      rqs_pkg::POL_AGING: limit = rqs_pkg::LIM_W'(1);
      default:            limit = '0;
    endcase
  end

  // queue cells: shift down on pop, age in place, open a hole on insert
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      if (cmd_i.pop) begin
        if (i < D - 1) begin
          slot_id_q[i]  <= slot_id_q[i+1];
          slot_len_q[i] <= slot_len_q[i+1];
          slot_sc_q[i]  <= slot_sc_q[i+1];
        end
      end else if (cmd_i.age) begin
        if (slot_sc_q[i] != '0) slot_sc_q[i] <= slot_sc_q[i] - KB'(1);
      end else if (cmd_i.insert) begin
        if (CW'(i) == pos) begin
          slot_id_q[i]  <= src_id;
          slot_len_q[i] <= src_len;
          slot_sc_q[i]  <= src_sc;
        end else if ((i >= 1) && (CW'(i) > pos)) begin
          slot_id_q[i]  <= slot_id_q[i-1];
          slot_len_q[i] <= slot_len_q[i-1];
          slot_sc_q[i]  <= slot_sc_q[i-1];
        end
      end
    end
    if (cmd_i.cmp) begin
      gt_q      <= gt_d;
      head_lt_q <= head_lt_d;
    end
    if (cmd_i.latch_item) begin
      item_kind_q <= rqs_pkg::kind_e'(kind_i);
      item_id_q   <= proc_id_i;
      item_len_q  <= job_length_i;
      item_sc_q   <= age_score_i;
      item_fin_q  <= finished_i;
    end
    if (cmd_i.load_result) begin
      granted_id_o <= cmd_i.grant ? run_id_q : '0;
      run_limit_o  <= cmd_i.grant ? limit : '0;
      status_o     <= cmd_i.res_status;
      occupancy_o  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      run_id_q    <= '0;
      run_len_q   <= '0;
      run_sc_q    <= '0;
      run_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cmd_i.pop) begin
        run_id_q    <= slot_id_q[0];
        run_len_q   <= slot_len_q[0];
        run_sc_q    <= slot_sc_q[0];
        run_valid_q <= 1'b1;
      end else if (cmd_i.clear_run) begin
        run_id_q    <= '0;
        run_len_q   <= '0;
        run_sc_q    <= '0;
        run_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.full        = (count_q == CW'(D));
    sts_o.empty       = (count_q == '0);
    sts_o.run_valid   = run_valid_q;
    sts_o.head_lt_run = slot_sc_q[0] < run_sc_q;
    sts_o.kind        = item_kind_q;
    sts_o.fin         = item_fin_q;
  end

endmodule

// ===== hdl/rqs_ctrl.sv =====
`timescale 1ns / 1ps
module rqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rqs_pkg::policy_e  policy_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rqs_pkg::sts_t     sts_i,
  output rqs_pkg::cmd_t     cmd_o
);

  rqs_pkg::state_e    state_q, state_d;
  rqs_pkg::status_e   res_q, res_d;
  logic               grant_q, grant_d;
  rqs_pkg::ins_mode_e mode_q, mode_d;
  logic               use_run_q, use_run_d;
  logic               out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rqs_pkg::S_IDLE;
      res_q       <= rqs_pkg::ST_OK;
      grant_q     <= 1'b0;
      mode_q      <= rqs_pkg::INS_TAIL;
      use_run_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_q       <= res_d;
      grant_q     <= grant_d;
      mode_q      <= mode_d;
      use_run_q   <= use_run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    res_d       = res_q;
    grant_d     = grant_q;
    mode_d      = mode_q;
    use_run_d   = use_run_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o             = '0;
    cmd_o.ins_mode    = mode_q;
    cmd_o.use_run     = use_run_q;
    cmd_o.grant       = grant_q;
    cmd_o.res_status  = res_q;

    unique case (state_q)
      rqs_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_item = 1'b1;
          res_d   = rqs_pkg::ST_OK;
          grant_d = 1'b0;
          state_d = rqs_pkg::S_DECODE;
        end
      end
      rqs_pkg::S_DECODE: begin
        state_d = rqs_pkg::S_DONE;
        unique case (sts_i.kind)
          rqs_pkg::KIND_ENQ: begin
            if (sts_i.full) begin
              res_d = rqs_pkg::ST_FULL;
            end else begin
              use_run_d = 1'b0;
              unique case (policy_i)
                rqs_pkg::POL_SJF:   mode_d = rqs_pkg::INS_SORT_LEN;
                rqs_pkg::POL_AGING: mode_d = rqs_pkg::INS_SORT_SC;
                default:            mode_d = rqs_pkg::INS_TAIL;
              endcase
              state_d = rqs_pkg::S_CMP;
            end
          end
          rqs_pkg::KIND_DISP: begin
            if (sts_i.run_valid) begin
              res_d = rqs_pkg::ST_NOPROC;
            end else if (sts_i.empty) begin
              res_d = rqs_pkg::ST_EMPTY;
            end else begin
              cmd_o.pop = 1'b1;
              grant_d   = 1'b1;
            end
          end
          rqs_pkg::KIND_REPORT: begin
            if (!sts_i.run_valid) begin
              res_d = rqs_pkg::ST_NOPROC;
            end else if (policy_i == rqs_pkg::POL_AGING) begin
              state_d = rqs_pkg::S_AGE;
            end else if (!sts_i.fin && policy_i == rqs_pkg::POL_RR) begin
              if (sts_i.full) begin
                res_d = rqs_pkg::ST_FULL;
                cmd_o.clear_run = 1'b1;
              end else begin
                mode_d    = rqs_pkg::INS_TAIL;
                use_run_d = 1'b1;
                state_d   = rqs_pkg::S_CMP;
              end
            end else begin
              cmd_o.clear_run = 1'b1;
            end
          end
          default: res_d = rqs_pkg::ST_NOPROC;
        endcase
      end
      rqs_pkg::S_AGE: begin
        cmd_o.age = 1'b1;
        if (sts_i.fin) begin
          cmd_o.clear_run = 1'b1;
          state_d = rqs_pkg::S_DONE;
        end else begin
          state_d = rqs_pkg::S_CHECK;
        end
      end
      rqs_pkg::S_CHECK: begin
        use_run_d = 1'b1;
        if (sts_i.full) begin
          res_d = rqs_pkg::ST_FULL;
          cmd_o.clear_run = 1'b1;
          state_d = rqs_pkg::S_DONE;
        end else begin
          mode_d  = (!sts_i.empty && sts_i.head_lt_run) ? rqs_pkg::INS_SORT_SC
                                                        : rqs_pkg::INS_HEAD;
          state_d = rqs_pkg::S_CMP;
        end
      end
      rqs_pkg::S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = rqs_pkg::S_WRITE;
      end
      rqs_pkg::S_WRITE: begin
        cmd_o.insert    = 1'b1;
        cmd_o.clear_run = use_run_q;
        state_d         = rqs_pkg::S_DONE;
      end
      rqs_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          out_valid_d = 1'b1;
          state_d     = rqs_pkg::S_IDLE;
        end
      end
      default: state_d = rqs_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hdl/ready_queue_scheduler.sv =====
`timescale 1ns / 1ps
// Ready queue scheduler: keeps up to 16 waiting processes (id, length,
// score) and serves enqueue, dispatch and slice-report requests under FCFS,
// SJF, round robin or aging (policy register). One request is worked at a
// time; each gives exactly one result transfer. Dispatch, retiring reports
// and rejected requests go straight to the result; an enqueue or round robin
// requeue first does a compare pass over all slots, then the shifting write.
// An aging report first ages every queued score; a finished process then
// retires, else a head check follows (full queue: rejected), then the compare
// pass and the write. The queue is a row of registers, so these steps do not
// depend on how full it is. A result may wait in the output register while
// the next request is already being worked. Configuration is a plain write
// port (index 0 policy, 1 quantum) and should only change while idle.
`include "ready_queue_scheduler_macros.svh"
module ready_queue_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [rqs_pkg::LIM_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    kind_i,
  input  logic [rqs_pkg::ID_W-1:0]      proc_id_i,
  input  logic [rqs_pkg::KEY_BITS-1:0]  job_length_i,
  input  logic [rqs_pkg::KEY_BITS-1:0]  age_score_i,
  input  logic                          finished_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rqs_pkg::ID_W-1:0]      granted_id_o,
  output logic [rqs_pkg::LIM_W-1:0]     run_limit_o,
  output logic [1:0]                    status_o,
  output logic [rqs_pkg::CNT_W-1:0]     occupancy_o
);

  rqs_pkg::policy_e          policy_q;
  logic [rqs_pkg::LIM_W-1:0] quantum_q;
  rqs_pkg::cmd_t             cmd;
  rqs_pkg::sts_t             sts;

  // config registers, reset to round robin with a quantum of 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= rqs_pkg::POL_RR;
      quantum_q <= rqs_pkg::LIM_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rqs_pkg::CFG_POLICY:  policy_q  <= rqs_pkg::policy_e'(cfg_wdata_i[1:0]);
        rqs_pkg::CFG_QUANTUM: quantum_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rqs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .policy_i    (policy_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rqs_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .policy_i     (policy_q),
    .quantum_i    (quantum_q),
    .kind_i       (kind_i),
    .proc_id_i    (proc_id_i),
    .job_length_i (job_length_i),
    .age_score_i  (age_score_i),
    .finished_i   (finished_i),
    .granted_id_o (granted_id_o),
    .run_limit_o  (run_limit_o),
    .status_o     (status_o),
    .occupancy_o  (occupancy_o)
  );

  // one request in flight: no second transfer right after one
  `RQS_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "accepted while busy")
  // a grant only comes with ok status
  `RQS_ASSERT_IMPL(a_limit_ok, out_valid_o && run_limit_o != '0, status_o == rqs_pkg::ST_OK, "limit without grant")
  // occupancy never exceeds the queue depth
  `RQS_ASSERT_IMPL(a_occ_range, out_valid_o, occupancy_o <= rqs_pkg::CNT_W'(rqs_pkg::QUEUE_DEPTH), "occupancy over depth")

endmodule
